### hw/rtl/dss_pkg.sv
package dss_pkg;

  localparam int DELIM_MAX = 8;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 4;
  localparam int FILL_W    = $clog2(DELIM_MAX + 1);
  localparam int CNT_W     = $clog2(DELIM_MAX + 2);
  localparam int DATA_W    = 64;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_BOUNDARY = 2'd1,
    KIND_END      = 2'd2,
    KIND_SHORT    = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    CFG_DELIM_BYTES = 1'b0,
    CFG_DELIM_LEN   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              is_final;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] out_byte;
    logic              run_end;
  } out_item_t;

  // Results of one input: ndata data bytes from the front of bytes, then
  // an optional boundary, then an optional end marker; or a short result.
  typedef struct packed {
    logic [DELIM_MAX-1:0][BYTE_W-1:0] bytes;
    logic [FILL_W-1:0]                ndata;
    logic                             boundary;
    logic                             fin;
    logic                             short_str;
    logic [CNT_W-1:0]                 count;
  } batch_t;

  function automatic logic [FILL_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [FILL_W-1:0] l;
    if (len == '0) begin
      l = FILL_W'(1);
    end else if (len > LEN_W'(DELIM_MAX)) begin
      l = FILL_W'(DELIM_MAX);
    end else begin
      l = FILL_W'(len);
    end
    return l;
  endfunction

endpackage

### hw/rtl/dss_core.sv
module dss_core (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  dss_pkg::in_item_t                         in_data,
  input  logic [dss_pkg::DELIM_MAX-1:0][dss_pkg::BYTE_W-1:0] delim,
  input  logic [dss_pkg::FILL_W-1:0]                len,
  input  logic                                      batch_room,
  output logic                                      batch_load,
  output dss_pkg::batch_t                           batch
);
  import dss_pkg::*;

  in_item_t                         item;
  logic                             item_valid;
  logic [DELIM_MAX-1:0][BYTE_W-1:0] window;
  logic [DELIM_MAX-1:0][BYTE_W-1:0] window_next;
  logic [FILL_W-1:0]                fill;
  logic [FILL_W-1:0]                fill_next;
  logic [FILL_W-1:0]                seen;
  logic [FILL_W-1:0]                seen_next;

  logic [DELIM_MAX-1:0][BYTE_W-1:0] ext;
  logic [DELIM_MAX-1:0][BYTE_W-1:0] slice;
  logic [FILL_W-1:0]                seen_inc;
  logic [FILL_W-1:0]                f1;
  logic [FILL_W-1:0]                pops;
  logic [FILL_W-1:0]                keep;
  logic [FILL_W-1:0]                ndata;
  logic                             short_hit;
  logic                             at_len;
  logic                             match;
  logic                             boundary;
  logic                             fin;
  logic                             has_res;
  logic                             advance;

  always_comb begin
    seen_inc  = (seen < FILL_W'(DELIM_MAX)) ? seen + FILL_W'(1) : seen;
    short_hit = item.is_final && (seen_inc < len);

    ext = window;
    for (int i = 0; i < DELIM_MAX; i++) begin
      if (FILL_W'(i) == fill) begin
        ext[i] = item.in_byte;
      end
    end
    f1     = (fill < FILL_W'(DELIM_MAX)) ? fill + FILL_W'(1) : fill;
    pops   = (f1 > len) ? f1 - len : '0;
    at_len = (f1 >= len);

    // Window contents after the excess bytes have left, oldest first.
    slice = '0;
    for (int j = 0; j < DELIM_MAX; j++) begin
      if (FILL_W'(j) == pops) begin
        for (int i = 0; i < DELIM_MAX; i++) begin
          slice[i] = (i + j < DELIM_MAX) ? ext[(i + j) % DELIM_MAX] : '0;
        end
      end
    end
    match = 1'b1;
    for (int i = 0; i < DELIM_MAX; i++) begin
      if ((FILL_W'(i) < len) && (slice[i] != delim[i])) begin
        match = 1'b0;
      end
    end

    boundary = !short_hit && at_len && match;
    fin      = !short_hit && item.is_final;
    keep     = at_len ? (match ? '0 : len - FILL_W'(1)) : f1;
    if (short_hit) begin
      ndata = '0;
    end else if (boundary) begin
      ndata = pops;
    end else if (item.is_final) begin
      ndata = f1;
    end else begin
      ndata = f1 - keep;
    end

    batch.bytes     = ext;
    batch.ndata     = ndata;
    batch.boundary  = boundary;
    batch.fin       = fin;
    batch.short_str = short_hit;
    batch.count     = short_hit ? CNT_W'(1)
                    : CNT_W'(ndata) + CNT_W'(boundary) + CNT_W'(fin);
    has_res         = (batch.count != '0);

    window_next = '0;
    for (int j = 0; j < DELIM_MAX; j++) begin
      if (FILL_W'(j) == ndata) begin
        for (int i = 0; i < DELIM_MAX; i++) begin
          window_next[i] = (i + j < DELIM_MAX) ? ext[(i + j) % DELIM_MAX] : '0;
        end
      end
    end
    if (short_hit || item.is_final) begin
      fill_next = '0;
      seen_next = '0;
    end else begin
      fill_next = boundary ? '0 : keep;
      seen_next = seen_inc;
    end
  end

  // An item with no results never waits for the result side.
  assign advance    = item_valid && (batch_room || !has_res);
  assign batch_load = advance && has_res;
  assign in_ready   = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      window     <= '0;
      fill       <= '0;
      seen       <= '0;
    end else begin
      if (in_valid && in_ready) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        window <= window_next;
        fill   <= fill_next;
        seen   <= seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

endmodule

### hw/rtl/dss_emit.sv
module dss_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                batch_load,
  input  dss_pkg::batch_t     batch,
  output logic                batch_room,
  output logic                out_valid,
  input  logic                out_ready,
  output dss_pkg::out_item_t  out_data
);
  import dss_pkg::*;

  batch_t            held;
  logic              held_valid;
  logic [CNT_W-1:0]  idx;
  logic              last;
  logic [BYTE_W-1:0] sel_byte;

  assign last       = (idx == held.count - CNT_W'(1));
  assign batch_room = !held_valid || (out_ready && last);
  assign out_valid  = held_valid;

  always_comb begin
    sel_byte = '0;
    for (int i = 0; i < DELIM_MAX; i++) begin
      if (CNT_W'(i) == idx) begin
        sel_byte = held.bytes[i];
      end
    end
    out_data.out_byte = '0;
    out_data.run_end  = last;
    priority if (held.short_str) begin
      out_data.kind = KIND_SHORT;
    end else if (idx < CNT_W'(held.ndata)) begin
      out_data.kind     = KIND_DATA;
      out_data.out_byte = sel_byte;
    end else if (held.boundary && (idx == CNT_W'(held.ndata))) begin
      out_data.kind = KIND_BOUNDARY;
    end else begin
      out_data.kind = KIND_END;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      idx        <= '0;
    end else if (batch_load) begin
      held_valid <= 1'b1;
      idx        <= '0;
    end else if (held_valid && out_ready) begin
      if (last) begin
        held_valid <= 1'b0;
      end else begin
        idx <= idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (batch_load) begin
      held <= batch;
    end
  end

endmodule

### hw/rtl/delimiter_string_splitter_top.sv
// A byte is held in the input register from its transfer, evaluated, and its
// results are loaded into the result register once that register has room;
// the first result is then offered from the result register.
// Throughput: one byte per cycle while each byte gives at most one result and
// results are taken as offered; a byte that gives several results keeps the
// result side busy until all are taken, and the next byte with results stalls
// the input until then. Bytes without results still pass.
// Reset (rst, synchronous, active high) empties both stages, clears the
// window, and sets the delimiter to all zero bytes with a length of one.
module delimiter_string_splitter_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  dss_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dss_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  dss_pkg::cfg_idx_t            cfg_index,
  input  logic [dss_pkg::DATA_W-1:0]   cfg_data
);
  import dss_pkg::*;

  logic [DATA_W-1:0] delim_bytes;
  logic [LEN_W-1:0]  delim_len;
  logic              batch_room;
  logic              batch_load;
  batch_t            batch;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_bytes <= '0;
      delim_len   <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DELIM_BYTES: delim_bytes <= cfg_data;
        CFG_DELIM_LEN:   delim_len   <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

  dss_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .delim      (delim_bytes[DELIM_MAX*BYTE_W-1:0]),
    .len        (eff_len(delim_len)),
    .batch_room (batch_room),
    .batch_load (batch_load),
    .batch      (batch)
  );

  dss_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .batch_load (batch_load),
    .batch      (batch),
    .batch_room (batch_room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### hw/rtl/dss_checker.sv
module dss_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input dss_pkg::out_item_t out_data
);
  import dss_pkg::*;

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed before transfer");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // Short-string and end results always close the results of their input.
  a_closing_kinds: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == KIND_SHORT || out_data.kind == KIND_END)
      |-> out_data.run_end)
    else $error("closing result without run_end");

  a_marker_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_DATA |-> out_data.out_byte == '0)
    else $error("marker result carries a nonzero byte");

endmodule

bind delimiter_string_splitter_top dss_checker u_dss_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dss_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_BYTES = 190;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  cfg_idx_t          cfg_index = CFG_DELIM_BYTES;
  logic [DATA_W-1:0] cfg_data  = '0;

  // Shadow copy of the delimiter registers and of the match window.
  logic [DATA_W-1:0] delim_shadow = '0;
  logic [LEN_W-1:0]  len_shadow   = LEN_W'(1);
  logic [BYTE_W-1:0] win_bytes [DELIM_MAX] = '{default: '0};
  int                win_fill = 0;
  int                str_seen = 0;

  in_item_t  pending_q  [$];
  out_item_t expected_q [$];

  int gap_cap   = 4;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int send_gap  = 0;
  int recv_gap  = 0;

  int cycle        = 0;
  int errors       = 0;
  int bytes_in     = 0;
  int strings_done = 0;
  int results_seen = 0;
  int settings     = 0;
  int queued       = 0;
  int kind_hits [4] = '{default: 0};

  always #5 clk = ~clk;

  delimiter_string_splitter_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int span(logic [LEN_W-1:0] len);
    if (len == '0) begin
      return 1;
    end
    if (len > DELIM_MAX) begin
      return DELIM_MAX;
    end
    return int'(len);
  endfunction

  function automatic int draw_gap();
    return (gap_cap == 0) ? 0 : int'($urandom_range(0, gap_cap));
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 100) begin
      $display("cycle %0d: %s", cycle, msg);
    end
  endtask

  task automatic push_expect(kind_t k, logic [BYTE_W-1:0] b);
    out_item_t r;
    r.kind     = k;
    r.out_byte = b;
    r.run_end  = 1'b0;
    expected_q.push_back(r);
  endtask

  task automatic emit_oldest();
    push_expect(KIND_DATA, win_bytes[0]);
    for (int i = 1; i < win_fill; i++) begin
      win_bytes[i-1] = win_bytes[i];
    end
    win_fill--;
  endtask

  function automatic bit window_is_delim(int l);
    for (int i = 0; i < l; i++) begin
      if (win_bytes[i] != delim_shadow[8*i +: 8]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Works out every result that one accepted byte causes.
  task automatic split_byte(in_item_t it);
    int        l;
    int        first;
    out_item_t last;
    l     = span(len_shadow);
    first = expected_q.size();
    if (str_seen < DELIM_MAX) begin
      str_seen++;
    end
    if (it.is_final && str_seen < l) begin
      push_expect(KIND_SHORT, '0);
      win_fill = 0;
      str_seen = 0;
    end else begin
      win_bytes[win_fill] = it.in_byte;
      win_fill++;
      // A length that shrank mid-string drains the surplus as data first.
      while (win_fill > l) begin
        emit_oldest();
      end
      if (win_fill == l) begin
        if (window_is_delim(l)) begin
          push_expect(KIND_BOUNDARY, '0);
          win_fill = 0;
        end else begin
          emit_oldest();
        end
      end
      if (it.is_final) begin
        while (win_fill > 0) begin
          emit_oldest();
        end
        push_expect(KIND_END, '0);
        str_seen = 0;
      end
    end
    if (it.is_final) begin
      strings_done++;
    end
    if (expected_q.size() > first) begin
      last = expected_q.pop_back();
      last.run_end = 1'b1;
      expected_q.push_back(last);
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    results_seen++;
    kind_hits[got.kind]++;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                got.kind, got.out_byte));
      return;
    end
    want = expected_q.pop_front();
    if (got.kind !== want.kind) begin
      report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
    end
    if (got.out_byte !== want.out_byte) begin
      report_mismatch($sformatf("out_byte %02h, expected %02h",
                                got.out_byte, want.out_byte));
    end
    if (got.run_end !== want.run_end) begin
      report_mismatch($sformatf("run_end %0b, expected %0b",
                                got.run_end, want.run_end));
    end
  endtask

  // Input driver: one transfer per pending byte, with a random gap before each.
  always @(posedge clk) begin
    logic     next_valid;
    in_item_t next_item;
    next_valid = in_valid;
    next_item  = in_data;
    if (rst) begin
      next_valid = 1'b0;
      send_gap   = 0;
    end else begin
      if (in_valid && in_ready) begin
        split_byte(in_data);
        bytes_in++;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_q.size() != 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else begin
          next_item  = pending_q.pop_front();
          next_valid = 1'b1;
          send_gap   = draw_gap();
        end
      end
    end
    in_valid <= next_valid;
    in_data  <= next_item;
  end

  // Result monitor: checks each transfer and throttles out_ready.
  always @(posedge clk) begin
    logic next_ready;
    next_ready = out_ready;
    if (rst) begin
      next_ready = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
        recv_gap = draw_gap();
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
    end
    out_ready <= next_ready;
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle, expected_q.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == CFG_DELIM_BYTES) begin
      delim_shadow = value;
    end else begin
      len_shadow = value[LEN_W-1:0];
    end
    settings++;
  endtask

  task automatic write_len(logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] word;
    word            = {$urandom, $urandom};
    word[LEN_W-1:0] = len;
    write_reg(CFG_DELIM_LEN, word);
  endtask

  task automatic push_byte(logic [BYTE_W-1:0] b, bit last);
    in_item_t it;
    it.in_byte  = b;
    it.is_final = last;
    pending_q.push_back(it);
    queued++;
  endtask

  // Builds a string mostly out of whole and partial delimiters so that
  // matches, near misses and overlaps are frequent.
  task automatic queue_string(int nbytes, bit close);
    logic [BYTE_W-1:0] text [$];
    int                l;
    int                k;
    int                r;
    l = span(len_shadow);
    while (text.size() < nbytes) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        for (int i = 0; i < l; i++) begin
          text.push_back(delim_shadow[8*i +: 8]);
        end
      end else if (r < 5) begin
        k = $urandom_range(1, l);
        for (int i = 0; i < k; i++) begin
          text.push_back(delim_shadow[8*i +: 8]);
        end
      end else if (r < 8) begin
        text.push_back(delim_shadow[8*$urandom_range(0, l - 1) +: 8]);
      end else begin
        text.push_back(BYTE_W'($urandom));
      end
    end
    for (int i = 0; i < nbytes; i++) begin
      push_byte(text[i], close && i == nbytes - 1);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) begin
      @(negedge clk);
    end
    // A trailing byte with no result may still be inside the block.
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [DATA_W-1:0] word;
    int                l;
    int                nstr;
    int                nbytes;
    int                phase;
    int                pick;
    logic [BYTE_W-1:0] b;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset delimiter is one zero byte: trailing delimiter leaves an empty segment.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_idle();

    // Two-byte delimiter: short string, leading and adjacent delimiters.
    word        = {$urandom, $urandom};
    word[15:0]  = 16'h0A0D;
    write_reg(CFG_DELIM_BYTES, word);
    write_len(4'd2);
    @(negedge clk);
    push_byte(8'h78, 1'b1);
    push_byte(8'h0D, 1'b0);
    push_byte(8'h0A, 1'b0);
    push_byte(8'h0D, 1'b0);
    push_byte(8'h0A, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h0D, 1'b0);
    push_byte(8'h0A, 1'b1);
    wait_idle();

    // Longest delimiter of all-ones bytes; the phase ends mid-string.
    write_reg(CFG_DELIM_BYTES, '1);
    write_len(4'd8);
    @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      push_byte(8'hFF, 1'b0);
    end
    push_byte(8'h00, 1'b1);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    wait_idle();

    // Length zero acts as one: the held bytes drain before the compare.
    word       = {$urandom, $urandom};
    word[7:0]  = 8'h44;
    write_reg(CFG_DELIM_BYTES, word);
    write_len(4'd0);
    @(negedge clk);
    push_byte(8'h44, 1'b1);
    push_byte(8'h55, 1'b0);
    wait_idle();

    // Length above the maximum: the string now counts as short.
    write_len(4'd15);
    @(negedge clk);
    push_byte(8'h66, 1'b1);
    wait_idle();

    phase = 0;
    while (queued < 26 + RANDOM_BYTES) begin
      phase++;
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        write_reg(CFG_DELIM_BYTES, {$urandom, $urandom});
      end else if (pick == 1) begin
        b = BYTE_W'($urandom);
        write_reg(CFG_DELIM_BYTES, {8{b}});
      end else if (pick == 2) begin
        for (int i = 0; i < 8; i++) begin
          word[8*i +: 8] = $urandom_range(0, 1) ? 8'h41 : 8'h42;
        end
        write_reg(CFG_DELIM_BYTES, word);
      end
      if ($urandom_range(0, 4) == 0) begin
        write_len(LEN_W'($urandom_range(0, 15)));
      end else begin
        write_len(LEN_W'($urandom_range(1, $urandom_range(1, 8))));
      end
      @(negedge clk);
      gap_cap <= ($urandom_range(0, 3) == 0) ? 0 : 4;
      nstr = $urandom_range(2, 5);
      if (phase == 2) begin
        // Hold results back long enough for the block to stall its input.
        hold_reqs <= hold_reqs + 1;
        nstr = 6;
      end
      l = span(len_shadow);
      for (int s = 0; s < nstr; s++) begin
        if ($urandom_range(0, 5) == 0 && l > 1) begin
          nbytes = $urandom_range(1, l - 1);
        end else begin
          nbytes = $urandom_range(1, 3 * l + 4);
        end
        queue_string(nbytes, !(s == nstr - 1 && $urandom_range(0, 3) == 0));
      end
      wait_idle();
    end

    repeat (6) @(negedge clk);
    if (expected_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    end
    $display("Split %0d bytes into %0d strings under %0d register writes.",
             bytes_in, strings_done, settings);
    $display("Checked %0d results: %0d data, %0d boundaries, %0d ends, %0d short.",
             results_seen, kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### delimiter_string_splitter_top.f
hw/rtl/dss_pkg.sv
hw/rtl/dss_core.sv
hw/rtl/dss_emit.sv
hw/rtl/delimiter_string_splitter_top.sv
hw/rtl/dss_checker.sv
sim/testbench.sv
